// ===== rtl/bre_pkg.sv =====
`timescale 1ns / 1ps

package bre_pkg;

    // Fixed geometry of the line stepper
    localparam int COORD_BITS = 16;
    localparam int TWICE_BITS = COORD_BITS + 2;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int COLOR_BITS = 32;

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 32'h00FF_FFFF;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [TWICE_BITS-1:0]        twice_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    // Input item as seen on the push side
    typedef struct packed
    {
        op_t    op;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } in_item_t;

    // Result item as seen on the pop side
    typedef struct packed
    {
        coord_t                pixel_x;
        coord_t                pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last;
    } out_item_t;

    // Classified command passed from the front end to the stepper
    typedef struct packed
    {
        op_t    op;
        coord_t first_x;
        coord_t first_y;
        coord_t major_end;
        twice_t twice_dx;
        twice_t twice_dy;
        err_t   err_init;
        logic   x_major;
        logic   minor_up;
    } cmd_t;

endpackage

// ===== rtl/bresenham_line_rasterizer.sv =====
`timescale 1ns / 1ps

// Bresenham line rasterizer. Push a load item (op 0) with two endpoints, then
// one step item (op 1) per pixel; each step yields the next pixel with the
// current draw_color, and the final pixel has last set. Steps while no line is
// loaded, and loads, produce nothing. Throughput is one item per clock while
// the result queue has room: the stepper's error update and coordinate
// advance are combinational. With the queues empty, a step item passes
// through the command queue and the stepper into the result queue before it
// can be popped. Two-entry queues sit between input and stepper and after the
// stepper, so either side may stall without stopping the other. draw_color is
// sampled when the pixel is produced; write it only when the block is idle.
module bresenham_line_rasterizer
    import bre_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              in_item,
    output logic                  empty,
    input  logic                  pop,
    output out_item_t             out_item,
    input  logic                  cfg_write,
    input  logic [COLOR_BITS-1:0] cfg_data
);

    logic [COLOR_BITS-1:0] draw_color_reg;
    cmd_t                  front_cmd;
    cmd_t                  head_cmd;
    logic                  cmd_empty;
    logic                  cmd_pop;
    logic                  out_full;
    logic                  out_push;
    out_item_t             step_item;

    // Color register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg <= COLOR_RESET;
        end
        else if (cfg_write)
        begin
            draw_color_reg <= cfg_data;
        end
    end

    bre_front u_front
    (
        .item (in_item),
        .cmd  (front_cmd)
    );

    bre_queue #(.ITEM_T(cmd_t)) u_cmd_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (head_cmd),
        .empty   (cmd_empty)
    );

    bre_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .color     (draw_color_reg),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (step_item)
    );

    bre_queue #(.ITEM_T(out_item_t)) u_out_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (step_item),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_item),
        .empty   (empty)
    );

endmodule

// ===== rtl/bre_queue.sv =====
`timescale 1ns / 1ps

// Two-entry queue; sustains one transfer per clock in both directions.
module bre_queue
    import bre_pkg::*;
#(
    parameter type ITEM_T = logic
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  ITEM_T wr_data,
    output logic  full,
    input  logic  rd_en,
    output ITEM_T rd_data,
    output logic  empty
);

    ITEM_T      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = count_reg[1];
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue occupancy out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");
`endif

endmodule

// ===== rtl/bre_front.sv =====
`timescale 1ns / 1ps

// Front end: classifies an item and, for a load, works out the line setup.
module bre_front
    import bre_pkg::*;
(
    input  in_item_t item,
    output cmd_t     cmd
);

    logic signed [COORD_BITS:0] diff_x;
    logic signed [COORD_BITS:0] diff_y;
    logic [COORD_BITS:0]        dx;
    logic [COORD_BITS:0]        dy;
    logic                       x_gt;
    logic                       y_gt;
    logic                       x_major;
    logic                       swap;
    coord_t                     first_x;
    coord_t                     first_y;
    coord_t                     last_x;
    coord_t                     last_y;

    // Absolute deltas and endpoint order
    always_comb
    begin
        diff_x = {item.x_start[COORD_BITS-1], item.x_start}
               - {item.x_end[COORD_BITS-1], item.x_end};
        diff_y = {item.y_start[COORD_BITS-1], item.y_start}
               - {item.y_end[COORD_BITS-1], item.y_end};
        dx     = diff_x[COORD_BITS] ? (-diff_x) : diff_x;
        dy     = diff_y[COORD_BITS] ? (-diff_y) : diff_y;
        x_gt   = !diff_x[COORD_BITS] && (diff_x != '0);
        y_gt   = !diff_y[COORD_BITS] && (diff_y != '0);
    end

    // Major axis choice (a tie goes to y) and swap so the major axis increases
    assign x_major = (dy < dx);
    assign swap    = x_major ? x_gt : y_gt;
    assign first_x = swap ? item.x_end   : item.x_start;
    assign first_y = swap ? item.y_end   : item.y_start;
    assign last_x  = swap ? item.x_start : item.x_end;
    assign last_y  = swap ? item.y_start : item.y_end;

    // Command fields
    always_comb
    begin
        cmd.op        = item.op;
        cmd.first_x   = first_x;
        cmd.first_y   = first_y;
        cmd.major_end = x_major ? last_x : last_y;
        cmd.twice_dx  = {dx, 1'b0};
        cmd.twice_dy  = {dy, 1'b0};
        cmd.err_init  = -$signed({2'b00, dx});
        cmd.x_major   = x_major;
        cmd.minor_up  = x_major ? (first_y < last_y) : (first_x < last_x);
    end

endmodule

// ===== rtl/bre_back.sv =====
`timescale 1ns / 1ps

// Back end: Bresenham stepper, one command per clock when the result side has room.
module bre_back
    import bre_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic                  cmd_empty,
    output logic                  cmd_pop,
    input  logic [COLOR_BITS-1:0] color,
    input  logic                  out_full,
    output logic                  out_push,
    output out_item_t             out_item
);

    logic   active_reg;
    logic   active_next;
    coord_t cur_x_reg;
    coord_t cur_x_next;
    coord_t cur_y_reg;
    coord_t cur_y_next;
    coord_t major_end_reg;
    err_t   err_reg;
    err_t   err_next;
    twice_t twice_dx_reg;
    twice_t twice_dy_reg;
    logic   x_major_reg;
    logic   minor_up_reg;

    logic   is_load;
    logic   is_step;
    logic   fin;
    err_t   err_add;
    err_t   err_sub;
    logic   minor_step;
    coord_t minor_delta;

    // Dispatch: a load or an idle step needs no result slot
    assign is_load  = !cmd_empty && (cmd.op == OP_LOAD);
    assign is_step  = !cmd_empty && (cmd.op == OP_STEP);
    assign out_push = is_step && active_reg && !out_full;
    assign cmd_pop  = is_load || (is_step && (!active_reg || !out_full));

    // Current pixel and end test
    assign fin = (x_major_reg ? cur_x_reg : cur_y_reg) == major_end_reg;

    always_comb
    begin
        out_item.pixel_x     = cur_x_reg;
        out_item.pixel_y     = cur_y_reg;
        out_item.pixel_color = color;
        out_item.last        = fin;
    end

    // Error update
    always_comb
    begin
        err_add     = err_reg + $signed({1'b0, x_major_reg ? twice_dy_reg : twice_dx_reg});
        err_sub     = err_add - $signed({1'b0, x_major_reg ? twice_dx_reg : twice_dy_reg});
        minor_step  = x_major_reg ? !err_add[ERR_BITS-1] : (err_add > 0);
        minor_delta = minor_up_reg ? coord_t'(1) : coord_t'(-1);
    end

    // Next state
    always_comb
    begin
        active_next = active_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_next    = err_reg;
        if (is_load)
        begin
            active_next = 1'b1;
            cur_x_next  = cmd.first_x;
            cur_y_next  = cmd.first_y;
            err_next    = cmd.err_init;
        end
        else if (out_push)
        begin
            active_next = !fin;
            err_next    = minor_step ? err_sub : err_add;
            if (x_major_reg)
            begin
                cur_x_next = cur_x_reg + coord_t'(1);
                cur_y_next = minor_step ? cur_y_reg + minor_delta : cur_y_reg;
            end
            else
            begin
                cur_y_next = cur_y_reg + coord_t'(1);
                cur_x_next = minor_step ? cur_x_reg + minor_delta : cur_x_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Line state, only meaningful while active
    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        err_reg   <= err_next;
        if (is_load)
        begin
            major_end_reg <= cmd.major_end;
            twice_dx_reg  <= cmd.twice_dx;
            twice_dy_reg  <= cmd.twice_dy;
            x_major_reg   <= cmd.x_major;
            minor_up_reg  <= cmd.minor_up;
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (active_reg && cmd_pop))
        else $error("pixel emitted without a line in progress");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && fin) |=> !active_reg)
        else $error("stepper still active after last pixel");

    a_load_active: assert property (@(posedge clk) disable iff (!rst_n)
        is_load |=> active_reg)
        else $error("load did not start a line");
`endif

endmodule
